// ===== rtl/dqc_pkg.sv =====
// Package for the dual quadrature counter: step table, divider constants
// and the control struct shared by the counter and top level.
// No dependencies.
package dqc_pkg;

  localparam int unsigned CountsPerRev = 1320;
  localparam logic [63:0] CircumUm = 64'd204204;
  localparam logic [63:0] UmPerMm = 64'd1000;
  localparam logic [63:0] Divisor = 64'(CountsPerRev) * UmPerMm;

  // The distance is formed as counts times a scaled reciprocal of the divisor,
  // which falls short of the true quotient by at most one.
  localparam int unsigned RecipShift = 50;
  localparam logic [63:0] Recip = (64'd1 << RecipShift) / Divisor;
  localparam logic [63:0] ScaledRecip = Recip * CircumUm;
  localparam int unsigned HalfW = 29;
  localparam int unsigned ProdW = 32 + HalfW;
  localparam int unsigned SumW = 32 + 2 * HalfW;
  localparam logic [HalfW-1:0] RecipLo = ScaledRecip[HalfW-1:0];
  localparam logic [HalfW-1:0] RecipHi = ScaledRecip[2*HalfW-1:HalfW];
  localparam logic [31:0] DivisorLow = Divisor[31:0];
  localparam logic [31:0] CircumLow = CircumUm[31:0];

  typedef logic signed [1:0] step_t;

  // Indexed by {previous phase, new phase}.
  localparam step_t StepTable [16] = '{
    2'b00, 2'b11, 2'b01, 2'b00,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b00, 2'b01, 2'b11, 2'b00
  };

  localparam step_t StepFwd = 2'b01;
  localparam step_t StepBack = 2'b11;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegLeftDir = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRightDir = 1'b1;

  typedef struct packed {
    logic advance;
    logic clear;
    logic flagged;
  } cnt_ctrl_t;

endpackage

// ===== rtl/dqc_counter.sv =====
// One quadrature decoder: previous phase, step lookup and signed total.
// Depends on dqc_pkg.
module dqc_counter import dqc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cnt_ctrl_t        ctrl_i,
  input  logic [1:0]       phase_i,
  input  logic signed [1:0] dir_i,
  output logic [31:0]      total_o
);

  logic [1:0]  prev_q, prev_d;
  logic [31:0] total_q, total_d;
  logic [31:0] dir_ext;
  logic [31:0] delta;
  step_t       step;

  assign step = StepTable[{prev_q, phase_i}];
  assign dir_ext = {{30{dir_i[1]}}, dir_i};

  always_comb begin
    case (step)
      StepFwd:  delta = dir_ext;
      StepBack: delta = 32'd0 - dir_ext;
      default:  delta = 32'd0;
    endcase
    prev_d = prev_q;
    total_d = total_q;
    if (ctrl_i.clear) begin
      prev_d = phase_i;
      total_d = 32'd0;
    end else if (ctrl_i.flagged) begin
      prev_d = phase_i;
      total_d = total_q + delta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 2'b00;
      total_q <= 32'd0;
    end else if (ctrl_i.advance) begin
      prev_q <= prev_d;
      total_q <= total_d;
    end
  end

  assign total_o = total_d;

endmodule

// ===== rtl/dqc_distance.sv =====
// Pipelined count-to-millimetre conversion: reciprocal multiply in two
// halves, wide add, then a one-step remainder correction. Depends on dqc_pkg.
module dqc_distance import dqc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] counts_i,
  output logic [31:0] dist_o
);

  logic [ProdW-1:0] prod_lo_q, prod_hi_q;
  logic [31:0]      plow2_q, plow3_q, plow4_q;
  logic [31:0]      qest3_q, qest4_q;
  logic [31:0]      qd4_q;
  logic [SumW-1:0]  sum;
  logic [31:0]      rem;

  assign sum = {prod_hi_q, {HalfW{1'b0}}} + SumW'(prod_lo_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_lo_q <= ProdW'(counts_i) * ProdW'(RecipLo);
      prod_hi_q <= ProdW'(counts_i) * ProdW'(RecipHi);
      plow2_q <= counts_i * CircumLow;
      qest3_q <= sum[RecipShift +: 32];
      plow3_q <= plow2_q;
      qd4_q <= qest3_q * DivisorLow;
      qest4_q <= qest3_q;
      plow4_q <= plow3_q;
    end
  end

  assign rem = plow4_q - qd4_q;
  assign dist_o = qest4_q + 32'(rem >= DivisorLow);

endmodule

// ===== rtl/dual_quadrature_counter.sv =====
// Dual 4x quadrature counter top level: input register, two decoders, the
// distance pipeline and the result register. Depends on dqc_pkg.
// A result moves from its input transfer through the pipeline stages to the result register.
// Throughput: one item per cycle; the five-stage pipeline holds when the
// result register is full and stalled, and the distance multiplies set the depth.
// Reset clears both counts and phases, sets both directions to +1 and empties the pipeline.
module dual_quadrature_counter import dqc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [1:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic               left_a_i,
  input  logic               left_b_i,
  input  logic               right_a_i,
  input  logic               right_b_i,
  input  logic               left_event_i,
  input  logic               right_event_i,
  input  logic [31:0]        convert_counts_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] left_count_o,
  output logic signed [31:0] right_count_o,
  output logic [31:0]        average_magnitude_o,
  output logic [31:0]        distance_mm_o
);

  logic        en;
  logic signed [1:0] left_dir_q, right_dir_q;
  logic        s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic        req_q, left_ev_q, right_ev_q;
  logic [1:0]  left_phase_q, right_phase_q;
  logic [31:0] counts_q;
  cnt_ctrl_t   left_ctrl, right_ctrl;
  logic [31:0] left_next, right_next;
  logic [31:0] left2_q, right2_q, left3_q, right3_q, left4_q, right4_q;
  logic [31:0] left_out_q, right_out_q, avg_out_q, dist_out_q;
  logic [31:0] avg3_q, avg4_q;
  logic [31:0] left_mag, right_mag, mag_sum;
  logic [31:0] dist_mm;

  assign en = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dir_q <= 2'sb01;
      right_dir_q <= 2'sb01;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLeftDir:  left_dir_q <= cfg_data_i;
        RegRightDir: right_dir_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign left_ctrl = '{advance: en && s1_valid_q, clear: req_q, flagged: left_ev_q};
  assign right_ctrl = '{advance: en && s1_valid_q, clear: req_q, flagged: right_ev_q};

  dqc_counter u_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (left_ctrl),
    .phase_i (left_phase_q),
    .dir_i   (left_dir_q),
    .total_o (left_next)
  );

  dqc_counter u_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (right_ctrl),
    .phase_i (right_phase_q),
    .dir_i   (right_dir_q),
    .total_o (right_next)
  );

  dqc_distance u_distance (
    .clk_i    (clk_i),
    .en_i     (en),
    .counts_i (counts_q),
    .dist_o   (dist_mm)
  );

  assign left_mag = left2_q[31] ? (32'd0 - left2_q) : left2_q;
  assign right_mag = right2_q[31] ? (32'd0 - right2_q) : right2_q;
  assign mag_sum = left_mag + right_mag;

  always_ff @(posedge clk_i) begin
    if (en) begin
      req_q <= req_type_i;
      left_phase_q <= {left_a_i, left_b_i};
      right_phase_q <= {right_a_i, right_b_i};
      left_ev_q <= left_event_i;
      right_ev_q <= right_event_i;
      counts_q <= convert_counts_i;
      left2_q <= left_next;
      right2_q <= right_next;
      left3_q <= left2_q;
      right3_q <= right2_q;
      avg3_q <= {1'b0, mag_sum[31:1]};
      left4_q <= left3_q;
      right4_q <= right3_q;
      avg4_q <= avg3_q;
      left_out_q <= left4_q;
      right_out_q <= right4_q;
      avg_out_q <= avg4_q;
      dist_out_q <= dist_mm;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_count_o = left_out_q;
  assign right_count_o = right_out_q;
  assign average_magnitude_o = avg_out_q;
  assign distance_mm_o = dist_out_q;

endmodule
